// ===== hdl/addressed_frame_deframer_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef ADDRESSED_FRAME_DEFRAMER_DEFINES_SVH
`define ADDRESSED_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/afd_pkg.sv =====
// Types and constants for the addressed frame deframer.
`timescale 1ns / 1ps

package afd_pkg;

    localparam logic [7:0] MAX_PAYLOAD = 8'd128;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CHK  = 3'd4,
        PH_END  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_ACCEPTED = 3'd1,
        KIND_WRONG    = 3'd2,
        KIND_CHKFAIL  = 3'd3,
        KIND_DROPPED  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_OWN_ADDRESS = 2'd0,
        REG_START_BYTE  = 2'd1,
        REG_END_BYTE    = 2'd2
    } cfg_reg_t;

endpackage

// ===== hdl/addressed_frame_deframer.sv =====
// Top level of the addressed frame deframer: byte-wise frame parser with status beats.
`timescale 1ns / 1ps
`include "addressed_frame_deframer_defines.svh"

// Accepts one received byte per clock. Each byte is parsed in the cycle it is
// accepted (a compare, an 8-bit checksum add and a phase update) and any
// resulting beat - a payload byte with its index and last mark, or a frame
// status - lands in the output register on the same edge, so it is visible
// in the cycle after acceptance. Bytes with no beat (hunting, matching address,
// length, good checksum) leave the output register empty. Input stalls only
// while a beat sits in the output register and the sink stalls it, so the
// sustained rate is one byte per cycle. The user writes configuration through
// the plain write port while the block is idle; the block does not enforce it.
module addressed_frame_deframer
    import afd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  byte_value,
    output logic [6:0]  payload_index,
    output logic        is_last,
    output logic [7:0]  frame_length
);

    logic [15:0] own_address_reg;
    logic [7:0]  start_byte_reg;
    logic [7:0]  end_byte_reg;

    phase_t      phase_reg,            phase_next;
    logic        addr_high_pending_reg, addr_high_pending_next;
    logic [7:0]  address_low_reg,      address_low_next;
    logic [7:0]  remaining_count_reg,  remaining_count_next;
    logic [7:0]  declared_length_reg,  declared_length_next;
    logic [7:0]  running_sum_reg,      running_sum_next;
    logic [6:0]  byte_position_reg,    byte_position_next;

    logic        out_valid_reg;
    kind_t       kind_reg,             kind_next;
    logic [7:0]  byte_value_reg,       byte_value_next;
    logic [6:0]  payload_index_reg,    payload_index_next;
    logic        is_last_reg,          is_last_next;
    logic [7:0]  frame_length_reg,     frame_length_next;
    logic        emit_next;

    logic        in_fire;
    logic        out_fire;

    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= 16'd0;
            start_byte_reg  <= 8'd2;
            end_byte_reg    <= 8'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OWN_ADDRESS: own_address_reg <= cfg_data;
                REG_START_BYTE:  start_byte_reg  <= cfg_data[7:0];
                REG_END_BYTE:    end_byte_reg    <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        phase_next             = phase_reg;
        addr_high_pending_next = addr_high_pending_reg;
        address_low_next       = address_low_reg;
        remaining_count_next   = remaining_count_reg;
        declared_length_next   = declared_length_reg;
        running_sum_next       = running_sum_reg;
        byte_position_next     = byte_position_reg;

        emit_next          = 1'b0;
        kind_next          = KIND_PAYLOAD;
        byte_value_next    = 8'd0;
        payload_index_next = 7'd0;
        is_last_next       = 1'b0;
        frame_length_next  = declared_length_reg;

        case (phase_reg)
            PH_ADDR:
            begin
                if (!addr_high_pending_reg)
                begin
                    address_low_next       = rx_byte;
                    running_sum_next       = rx_byte;
                    addr_high_pending_next = 1'b1;
                end
                else
                begin
                    addr_high_pending_next = 1'b0;
                    if ({rx_byte, address_low_reg} == own_address_reg)
                    begin
                        running_sum_next = running_sum_reg + rx_byte;
                        phase_next       = PH_LEN;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        emit_next  = 1'b1;
                        kind_next  = KIND_WRONG;
                    end
                end
            end
            PH_LEN:
            begin
                if (rx_byte != 8'd0 && rx_byte <= MAX_PAYLOAD)
                begin
                    declared_length_next = rx_byte;
                    remaining_count_next = rx_byte;
                    running_sum_next     = running_sum_reg + rx_byte;
                    phase_next           = PH_DATA;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_DATA:
            begin
                emit_next            = 1'b1;
                kind_next            = KIND_PAYLOAD;
                byte_value_next      = rx_byte;
                payload_index_next   = byte_position_reg;
                is_last_next         = (remaining_count_reg <= 8'd1);
                running_sum_next     = running_sum_reg + rx_byte;
                byte_position_next   = byte_position_reg + 7'd1;
                remaining_count_next = remaining_count_reg - 8'd1;
                if (remaining_count_reg == 8'd1)
                begin
                    phase_next = PH_CHK;
                end
            end
            PH_CHK:
            begin
                if (rx_byte == running_sum_reg)
                begin
                    phase_next = PH_END;
                end
                else
                begin
                    phase_next = PH_HUNT;
                    emit_next  = 1'b1;
                    kind_next  = KIND_CHKFAIL;
                end
            end
            PH_END:
            begin
                phase_next = PH_HUNT;
                emit_next  = 1'b1;
                kind_next  = (rx_byte == end_byte_reg) ? KIND_ACCEPTED : KIND_DROPPED;
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (rx_byte == start_byte_reg)
                begin
                    byte_position_next     = 7'd0;
                    remaining_count_next   = 8'd0;
                    declared_length_next   = 8'd0;
                    running_sum_next       = 8'd0;
                    addr_high_pending_next = 1'b0;
                    phase_next             = PH_ADDR;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_HUNT;
            addr_high_pending_reg <= 1'b0;
            address_low_reg       <= 8'd0;
            remaining_count_reg   <= 8'd0;
            declared_length_reg   <= 8'd0;
            running_sum_reg       <= 8'd0;
            byte_position_reg     <= 7'd0;
        end
        else if (in_fire)
        begin
            phase_reg             <= phase_next;
            addr_high_pending_reg <= addr_high_pending_next;
            address_low_reg       <= address_low_next;
            remaining_count_reg   <= remaining_count_next;
            declared_length_reg   <= declared_length_next;
            running_sum_reg       <= running_sum_next;
            byte_position_reg     <= byte_position_next;
        end
    end

    // Load a new beat on acceptance; otherwise drop the old one once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= emit_next;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit_next)
        begin
            kind_reg          <= kind_next;
            byte_value_reg    <= byte_value_next;
            payload_index_reg <= payload_index_next;
            is_last_reg       <= is_last_next;
            frame_length_reg  <= frame_length_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign byte_value    = byte_value_reg;
    assign payload_index = payload_index_reg;
    assign is_last       = is_last_reg;
    assign frame_length  = frame_length_reg;

    `AFD_ASSERT_NEXT(a_data_gives_payload, clk, rst_n,
        in_fire && phase_reg == PH_DATA,
        out_valid_reg && kind_reg == KIND_PAYLOAD,
        "payload byte did not produce a payload beat")
    `AFD_ASSERT_NEXT(a_silent_phases_no_beat, clk, rst_n,
        in_fire && (phase_reg == PH_LEN || phase_reg == PH_HUNT),
        !out_valid_reg,
        "hunting or length byte produced a beat")
    `AFD_ASSERT_NOW(a_data_count_sane, clk, rst_n,
        phase_reg == PH_DATA,
        remaining_count_reg != 8'd0 && remaining_count_reg <= declared_length_reg
            && declared_length_reg <= MAX_PAYLOAD,
        "payload counters out of range")
    `AFD_ASSERT_NOW(a_status_fields_clear, clk, rst_n,
        out_valid_reg && kind_reg != KIND_PAYLOAD,
        byte_value_reg == 8'd0 && payload_index_reg == 7'd0 && !is_last_reg,
        "status beat carries payload fields")

endmodule
